// File: rtl/rwps_pkg.sv
// Shared constants, types and state encoding for the roulette-wheel parent selector.
`timescale 1ns / 1ps
package rwps_pkg;

   localparam int POP_MAX  = 256;
   localparam int IDX_W    = $clog2(POP_MAX);
   localparam int CNT_W    = $clog2(POP_MAX + 1);
   localparam int CFG_W    = 9;
   localparam int MARK_W   = 24;
   localparam int RAND_W   = 32;
   localparam int SUM_W    = MARK_W + IDX_W + 1;
   localparam int PROD_W   = CNT_W + MARK_W + 2;
   localparam int PIDX_W   = 8;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam logic [CFG_W-1:0] POP_SIZE_RESET = CFG_W'(256);

   localparam logic CSR_POP_SIZE = 1'b0;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DRAW = 1'b1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_TOTAL  = 6'b000010,
      S_DIV    = 6'b000100,
      S_PROBE  = 6'b001000,
      S_CMP    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

endpackage

// File: rtl/rwps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rwps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/rwps_mod_unit.sv
// Iterative restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module rwps_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rwps_pkg::RAND_W-1:0] dividend,
   input  logic [rwps_pkg::SUM_W-1:0]  divisor,
   output logic                        done,
   output logic [rwps_pkg::SUM_W-1:0]  remainder
);
   import rwps_pkg::*;

   localparam int STEP_W = $clog2(RAND_W);

   logic                run_ff, run_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [RAND_W-1:0]   dvd_ff, dvd_in;
   logic [SUM_W-1:0]    dvs_ff, dvs_in;
   logic [SUM_W-1:0]    rem_ff, rem_in;
   logic [SUM_W:0]      shifted;
   logic [SUM_W:0]      trial;
   logic                last_step;

   assign shifted   = {rem_ff, dvd_ff[RAND_W-1]};
   assign trial     = shifted - {1'b0, dvs_ff};
   assign last_step = (step_ff == STEP_W'(RAND_W - 1));

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (run_ff) begin
         dvd_in  = {dvd_ff[RAND_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         rem_in  = trial[SUM_W] ? shifted[SUM_W-1:0] : trial[SUM_W-1:0];
         if (last_step) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = run_ff && last_step;
   assign remainder = rem_ff;

   property p_rem_below_divisor;
      @(posedge clock) disable iff (reset)
         (run_ff && !start && dvs_ff != '0) |=> (rem_ff < dvs_ff);
   endproperty
   a_rem_below_divisor: assert property (p_rem_below_divisor)
      else $error("remainder not reduced below divisor");

   property p_done_ends_run;
      @(posedge clock) disable iff (reset)
         (done && !start) |=> !run_ff;
   endproperty
   a_done_ends_run: assert property (p_done_ends_run)
      else $error("remainder unit still running after done");

   property p_done_once;
      @(posedge clock) disable iff (reset)
         done |=> !done;
   endproperty
   a_done_once: assert property (p_done_once)
      else $error("remainder unit done held for two cycles");

endmodule

// File: rtl/roulette_wheel_parent_select.sv
// Top level: fitness loading, prefix sums and roulette-wheel parent draws.
// Load request: result in the cycle after acceptance; a new request may follow at once.
// Draw request: the total-weight state, 32 remainder-unit steps, then s <= ceil(log2(loaded
//   count)) search steps, each a probe/compare pair on the prefix-sum RAM read port, then
//   the finish state and the registered result.
// busy is high for the whole draw; the result strobe is never stalled.
// Synchronous reset: population_size 256, loading phase, counts 0; RAM is not cleared.
`timescale 1ns / 1ps
module roulette_wheel_parent_select (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [rwps_pkg::MARK_W-1:0]   req_fitness_mark,
   input  logic [rwps_pkg::RAND_W-1:0]   req_random_word,
   output logic                          rsp_strobe,
   output logic [rwps_pkg::PIDX_W-1:0]   rsp_parent_index,
   output logic                          rsp_index_valid,
   output logic                          rsp_generation_done,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rwps_pkg::ADDR_W-1:0]   paddr,
   input  logic [rwps_pkg::DATA_W-1:0]   pwdata,
   output logic [rwps_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import rwps_pkg::*;

   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        pop_size_ff, pop_size_in;
   logic                    drawing_ff, drawing_in;
   logic [CNT_W-1:0]        loaded_ff, loaded_in;
   logic [CNT_W-1:0]        drawn_ff, drawn_in;
   logic signed [MARK_W-1:0] least_ff, least_in;
   logic [SUM_W-1:0]        run_sum_ff, run_sum_in;
   logic [RAND_W-1:0]       rand_ff, rand_in;
   logic [IDX_W-1:0]        lo_ff, lo_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                    strobe_ff, strobe_in;
   logic [PIDX_W-1:0]       pidx_ff, pidx_in;
   logic                    valid_ff, valid_in;
   logic                    gdone_ff, gdone_in;

   logic                    accept;
   logic                    csr_write;
   logic [CNT_W-1:0]        eff_n;
   logic signed [SUM_W-1:0] mark_ext;
   logic [CNT_W-1:0]        load_next;
   logic [CNT_W-1:0]        drawn_next;
   logic                    ram_we;
   logic [SUM_W-1:0]        ram_rdata;
   logic [IDX_W:0]          lo_hi_sum;
   logic [IDX_W-1:0]        mid;
   logic [CNT_W-1:0]        mul_count;
   logic signed [MARK_W:0]  shift;
   logic signed [PROD_W-1:0] product;
   logic [SUM_W-1:0]        diff_src;
   logic signed [PROD_W-1:0] diff;
   logic                    ge;
   logic [IDX_W-1:0]        hi_init;
   logic                    div_start;
   logic                    div_done;
   logic [SUM_W-1:0]        div_rem;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_write = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == CSR_POP_SIZE);
   assign pready    = 1'b1;
   assign prdata    = (paddr[ADDR_W-1] == CSR_POP_SIZE) ? DATA_W'(pop_size_ff) : '0;

   always_comb begin
      if (pop_size_ff == '0) begin
         eff_n = CNT_W'(1);
      end else if (32'(pop_size_ff) > POP_MAX) begin
         eff_n = CNT_W'(POP_MAX);
      end else begin
         eff_n = CNT_W'(pop_size_ff);
      end
   end

   assign mark_ext   = SUM_W'($signed(req_fitness_mark));
   assign load_next  = loaded_ff + CNT_W'(1);
   assign drawn_next = drawn_ff + CNT_W'(1);
   assign ram_we     = accept && (req_type == REQ_LOAD) && !drawing_ff;
   assign run_sum_in = (loaded_ff == '0) ? mark_ext : run_sum_ff + mark_ext;

   assign lo_hi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid        = lo_hi_sum[IDX_W:1];
   assign mul_count  = (state_ff == S_IDLE) ? loaded_ff : CNT_W'(mid) + CNT_W'(1);
   assign shift      = (MARK_W + 1)'(least_ff) - (MARK_W + 1)'(1);
   assign product    = PROD_W'($signed({1'b0, mul_count}) * shift);
   assign diff_src   = (state_ff == S_CMP) ? ram_rdata : run_sum_ff;
   assign diff       = PROD_W'($signed(diff_src)) - prod_ff;
   assign ge         = (diff >= $signed(PROD_W'(div_rem)));
   assign hi_init    = IDX_W'(loaded_ff - CNT_W'(1));
   assign div_start  = (state_ff == S_TOTAL);

   rwps_ram #(
      .WIDTH(SUM_W),
      .DEPTH(POP_MAX)
   ) u_prefix_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (IDX_W'(loaded_ff)),
      .wdata (run_sum_in),
      .raddr (mid),
      .rdata (ram_rdata)
   );

   rwps_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (rand_ff),
      .divisor   (diff[SUM_W-1:0]),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in    = state_ff;
      pop_size_in = pop_size_ff;
      drawing_in  = drawing_ff;
      loaded_in   = loaded_ff;
      drawn_in    = drawn_ff;
      least_in    = least_ff;
      rand_in     = rand_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      strobe_in   = 1'b0;
      pidx_in     = '0;
      valid_in    = 1'b0;
      gdone_in    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_write) begin
               pop_size_in = pwdata[CFG_W-1:0];
               drawing_in  = 1'b0;
               loaded_in   = '0;
               drawn_in    = '0;
               least_in    = '0;
            end else if (accept) begin
               if (req_type == REQ_LOAD && !drawing_ff) begin
                  strobe_in = 1'b1;
                  loaded_in = load_next;
                  if (loaded_ff == '0 || $signed(req_fitness_mark) < least_ff) begin
                     least_in = $signed(req_fitness_mark);
                  end
                  if (load_next >= eff_n) begin
                     drawing_in = 1'b1;
                     drawn_in   = '0;
                  end
               end else if (req_type == REQ_DRAW && drawing_ff) begin
                  rand_in  = req_random_word;
                  state_in = S_TOTAL;
               end else begin
                  strobe_in = 1'b1;
               end
            end
         end
         S_TOTAL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               lo_in    = '0;
               hi_in    = hi_init;
               state_in = (hi_init != '0) ? S_PROBE : S_FINISH;
            end
         end
         S_PROBE: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ge) begin
               hi_in = mid;
            end else begin
               lo_in = mid + IDX_W'(1);
            end
            state_in = (lo_in < hi_in) ? S_PROBE : S_FINISH;
         end
         S_FINISH: begin
            strobe_in = 1'b1;
            pidx_in   = PIDX_W'(lo_ff);
            valid_in  = 1'b1;
            drawn_in  = drawn_next;
            if (drawn_next >= loaded_ff) begin
               gdone_in   = 1'b1;
               drawing_in = 1'b0;
               loaded_in  = '0;
               drawn_in   = '0;
               least_in   = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pop_size_ff <= POP_SIZE_RESET;
         drawing_ff  <= 1'b0;
         loaded_ff   <= '0;
         drawn_ff    <= '0;
         least_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pop_size_ff <= pop_size_in;
         drawing_ff  <= drawing_in;
         loaded_ff   <= loaded_in;
         drawn_ff    <= drawn_in;
         least_ff    <= least_in;
         strobe_ff   <= strobe_in;
      end
      if (ram_we) begin
         run_sum_ff <= run_sum_in;
      end
      rand_ff  <= rand_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      prod_ff  <= product;
      pidx_ff  <= pidx_in;
      valid_ff <= valid_in;
      gdone_ff <= gdone_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_parent_index    = pidx_ff;
   assign rsp_index_valid     = valid_ff;
   assign rsp_generation_done = gdone_ff;

   property p_accept_answered;
      @(posedge clock) disable iff (reset)
         (accept && !csr_write) |=> (rsp_strobe || busy);
   endproperty
   a_accept_answered: assert property (p_accept_answered)
      else $error("accepted request neither answered nor in progress");

   property p_done_has_index;
      @(posedge clock) disable iff (reset)
         (rsp_strobe && rsp_generation_done) |-> rsp_index_valid;
   endproperty
   a_done_has_index: assert property (p_done_has_index)
      else $error("generation done without a drawn parent");

   property p_index_in_range;
      @(posedge clock) disable iff (reset)
         (rsp_strobe && rsp_index_valid && !rsp_generation_done) |->
            (CNT_W'(rsp_parent_index) < loaded_ff);
   endproperty
   a_index_in_range: assert property (p_index_in_range)
      else $error("drawn parent index beyond loaded marks");

   property p_div_done_in_div;
      @(posedge clock) disable iff (reset)
         div_done |-> (state_ff == S_DIV);
   endproperty
   a_div_done_in_div: assert property (p_div_done_in_div)
      else $error("remainder unit finished outside the modulo step");

   property p_drawing_has_marks;
      @(posedge clock) disable iff (reset)
         drawing_ff |-> (loaded_ff != '0);
   endproperty
   a_drawing_has_marks: assert property (p_drawing_has_marks)
      else $error("drawing phase with no marks loaded");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the roulette-wheel parent selector.
`timescale 1ns / 1ps
module tb_top;
   import rwps_pkg::*;

   typedef struct packed {
      logic [PIDX_W-1:0] parent_index;
      logic              index_valid;
      logic              generation_done;
   } pick_type;

   typedef struct {
      bit                cfg_row;
      logic              rtype;
      logic [MARK_W-1:0] mark;
      logic [RAND_W-1:0] word;
      logic [DATA_W-1:0] cfg_data;
      bit                typed;
      pick_type          want;
   } step_row_type;

   localparam logic [ADDR_W-1:0] POP_SIZE_ADDR = ADDR_W'(int'(CSR_POP_SIZE) * 4);
   localparam int                PHASE_ITEMS   = 500;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_type = REQ_LOAD;
   logic [MARK_W-1:0]   req_fitness_mark = '0;
   logic [RAND_W-1:0]   req_random_word = '0;
   logic                rsp_strobe;
   logic [PIDX_W-1:0]   rsp_parent_index;
   logic                rsp_index_valid;
   logic                rsp_generation_done;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // selector shadow state
   logic [CFG_W-1:0]    gen_size = POP_SIZE_RESET;
   bit                  in_draw = 1'b0;
   int                  marks_loaded = 0;
   int                  picks_made = 0;
   longint              floor_mark = 0;
   longint              mark_sums [POP_MAX];

   pick_type            pending_picks [$];
   step_row_type        steps [$];
   int                  error_count = 0;
   int                  idle_pct = 0;

   always #5 clock = ~clock;

   roulette_wheel_parent_select u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_type            (req_type),
      .req_fitness_mark    (req_fitness_mark),
      .req_random_word     (req_random_word),
      .rsp_strobe          (rsp_strobe),
      .rsp_parent_index    (rsp_parent_index),
      .rsp_index_valid     (rsp_index_valid),
      .rsp_generation_done (rsp_generation_done),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   task automatic flag(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   function automatic void restart_gen();
      in_draw = 1'b0;
      marks_loaded = 0;
      picks_made = 0;
      floor_mark = 0;
   endfunction

   // fitness-proportional pick: first index whose cumulative weight reaches r
   function automatic pick_type predict_pick(input logic rtype, input logic [MARK_W-1:0] mark,
                                             input logic [RAND_W-1:0] word);
      pick_type res;
      int       n;
      int       j;
      longint   m;
      longint   shift;
      longint   total;
      longint   r;
      res = '0;
      n = (gen_size == 0) ? 1 : (int'(gen_size) > POP_MAX) ? POP_MAX : int'(gen_size);
      if (rtype == REQ_LOAD && !in_draw) begin
         m = longint'($signed(mark));
         if (marks_loaded == 0) begin
            floor_mark = m;
            mark_sums[0] = m;
         end else begin
            if (m < floor_mark) floor_mark = m;
            mark_sums[marks_loaded] = mark_sums[marks_loaded-1] + m;
         end
         marks_loaded++;
         if (marks_loaded >= n) begin
            in_draw = 1'b1;
            picks_made = 0;
         end
      end else if (rtype == REQ_DRAW && in_draw) begin
         shift = floor_mark - 1;
         total = mark_sums[marks_loaded-1] - longint'(marks_loaded) * shift;
         r = longint'({32'h0, word}) % total;
         j = 0;
         while (mark_sums[j] - longint'(j + 1) * shift < r) j++;
         res.parent_index = PIDX_W'(j);
         res.index_valid = 1'b1;
         picks_made++;
         if (picks_made >= marks_loaded) begin
            res.generation_done = 1'b1;
            restart_gen();
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : check_rsp
      pick_type want;
      if (!reset && rsp_strobe) begin
         if (pending_picks.size() == 0) begin
            flag($sformatf("result with nothing pending: idx=%0d valid=%0b done=%0b",
                           rsp_parent_index, rsp_index_valid, rsp_generation_done));
         end else begin
            want = pending_picks.pop_front();
            if (rsp_parent_index !== want.parent_index)
               flag($sformatf("parent_index exp %0d got %0d", want.parent_index,
                              rsp_parent_index));
            if (rsp_index_valid !== want.index_valid)
               flag($sformatf("index_valid exp %0b got %0b", want.index_valid,
                              rsp_index_valid));
            if (rsp_generation_done !== want.generation_done)
               flag($sformatf("generation_done exp %0b got %0b", want.generation_done,
                              rsp_generation_done));
         end
      end
   end

   task automatic issue_request(input logic rtype, input logic [MARK_W-1:0] mark,
                                input logic [RAND_W-1:0] word, input bit typed,
                                input pick_type want);
      pick_type got;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= rtype;
      req_fitness_mark <= mark;
      req_random_word <= word;
      do @(posedge clock); while (busy);
      got = predict_pick(rtype, mark, word);
      pending_picks.push_back(typed ? want : got);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [DATA_W-1:0] data,
                             output logic [DATA_W-1:0] rdata);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= POP_SIZE_ADDR;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_pop_size(input logic [DATA_W-1:0] data);
      logic [DATA_W-1:0] rd;
      csr_access(1'b1, data, rd);
      gen_size = data[CFG_W-1:0];
      restart_gen();
      csr_access(1'b0, '0, rd);
      if (rd[CFG_W-1:0] !== data[CFG_W-1:0])
         flag($sformatf("population_size readback exp %0d got %0d", data[CFG_W-1:0],
                        rd[CFG_W-1:0]));
   endtask

   task automatic add_cfg(input logic [DATA_W-1:0] data);
      step_row_type row;
      row = '{default: '0};
      row.cfg_row = 1'b1;
      row.cfg_data = data;
      steps.push_back(row);
   endtask

   task automatic add_req(input logic rtype, input logic [MARK_W-1:0] mark,
                          input logic [RAND_W-1:0] word, input bit typed,
                          input int idx, input bit valid, input bit done);
      step_row_type row;
      row = '{default: '0};
      row.rtype = rtype;
      row.mark = mark;
      row.word = word;
      row.typed = typed;
      row.want.parent_index = PIDX_W'(idx);
      row.want.index_valid = valid;
      row.want.generation_done = done;
      steps.push_back(row);
   endtask

   function automatic logic [MARK_W-1:0] pick_mark(input int mode,
                                                   input logic [MARK_W-1:0] base);
      case (mode)
         0: return MARK_W'($urandom);
         1: return MARK_W'($signed($urandom_range(16)) - 8);
         2: begin
            case ($urandom_range(3))
               0: return {1'b1, {(MARK_W-1){1'b0}}};
               1: return {1'b0, {(MARK_W-1){1'b1}}};
               2: return '0;
               default: return '1;
            endcase
         end
         default: return base;
      endcase
   endfunction

   function automatic logic [RAND_W-1:0] pick_word();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom;
      if (sel < 85) return RAND_W'($urandom_range(20));
      return (sel < 92) ? '0 : '1;
   endfunction

   initial begin : timeout
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int                phase;
      int                phase_items;
      int                gen_num;
      int                n;
      int                cut;
      int                mode;
      int                size;
      bit                broken;
      logic [MARK_W-1:0] base;
      logic [DATA_W-1:0] cfg;
      pick_type          none;
      int                pct [4];

      pct = '{0, 48, 0, 37};
      none = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      add_req(REQ_DRAW, 24'h123456, 32'hFFFF_FFFF, 1, 0, 0, 0);
      add_cfg(32'd0);
      add_req(REQ_LOAD, 24'h80_0000, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'h00_0005, 32'h0, 1, 0, 0, 0);
      add_req(REQ_DRAW, 24'h0, 32'hFFFF_FFFF, 1, 0, 1, 1);
      add_cfg(32'd3);
      add_req(REQ_LOAD, 24'h7F_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'h80_0000, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'h00_0000, 32'h0, 1, 0, 0, 0);
      add_req(REQ_DRAW, 24'hFF_FFFF, 32'h0, 1, 0, 1, 0);
      add_req(REQ_DRAW, 24'h0, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_req(REQ_DRAW, 24'h0, 32'h1234_5678, 0, 0, 0, 0);
      add_cfg(32'hFFFF_FFFF);
      add_req(REQ_LOAD, 24'd100, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, -24'sd100, 32'h0, 1, 0, 0, 0);
      add_cfg(32'd2);
      add_req(REQ_DRAW, 24'h0, 32'h5, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'd7, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'd7, 32'h0, 1, 0, 0, 0);
      add_req(REQ_DRAW, 24'h0, 32'h1, 0, 0, 0, 0);
      add_req(REQ_DRAW, 24'h0, 32'h8000_0000, 0, 0, 0, 0);
      add_cfg(32'd4);
      add_req(REQ_LOAD, -24'sd1, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'd1000, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, -24'sd1, 32'h0, 1, 0, 0, 0);
      add_req(REQ_LOAD, 24'd3, 32'h0, 1, 0, 0, 0);
      for (int k = 0; k < 4; k++) add_req(REQ_DRAW, 24'h0, 32'd500 + 400 * k, 0, 0, 0, 0);

      foreach (steps[i]) begin
         if (steps[i].cfg_row) begin
            wait_idle();
            set_pop_size(steps[i].cfg_data);
         end else begin
            issue_request(steps[i].rtype, steps[i].mark, steps[i].word, steps[i].typed,
                          steps[i].want);
         end
      end

      // random generations
      for (phase = 0; phase < 4; phase++) begin
         idle_pct = pct[phase];
         phase_items = 0;
         gen_num = 0;
         while (phase_items < PHASE_ITEMS) begin
            if (gen_num == 0 && phase == 1) size = 511;
            else if (gen_num == 0 && phase == 2) size = 256;
            else if (gen_num == 0 && phase == 3) size = 0;
            else if ($urandom_range(99) < 75) size = $urandom_range(1, 8);
            else if ($urandom_range(99) < 80) size = $urandom_range(9, 32);
            else size = $urandom_range(33, 64);
            cfg = $urandom;
            cfg[CFG_W-1:0] = CFG_W'(size);
            wait_idle();
            set_pop_size(cfg);
            n = (size == 0) ? 1 : (size > POP_MAX) ? POP_MAX : size;
            broken = ($urandom_range(99) < 6);
            cut = $urandom_range(2 * n - 1);
            mode = $urandom_range(3);
            base = MARK_W'($urandom);
            for (int i = 0; i < 2 * n; i++) begin
               if (broken && i == cut) break;
               if ($urandom_range(99) < 4) begin
                  if (i < n) issue_request(REQ_DRAW, MARK_W'($urandom), pick_word(), 0, none);
                  else issue_request(REQ_LOAD, MARK_W'($urandom), $urandom, 0, none);
               end
               if (i < n) issue_request(REQ_LOAD, pick_mark(mode, base), $urandom, 0, none);
               else issue_request(REQ_DRAW, MARK_W'($urandom), pick_word(), 0, none);
               phase_items++;
            end
            gen_num++;
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
